@@ rtl/rv32_alu_instruction_execute_macros.svh @@
// ----------------------------------------------------------------------------
// rv32_alu_instruction_execute_macros
// Assertion macros shared by the execute block.
// ----------------------------------------------------------------------------
`ifndef RV32_ALU_INSTRUCTION_EXECUTE_MACROS_SVH
`define RV32_ALU_INSTRUCTION_EXECUTE_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define RV32ALU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define RV32ALU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/rv32alu_pkg.sv @@
// ----------------------------------------------------------------------------
// rv32alu_pkg
// Shared types and encoding constants for the RV32 ALU execute block.
// ----------------------------------------------------------------------------
package rv32alu_pkg;

  localparam int XLEN   = 32;
  localparam int NREGS  = 32;
  localparam int RIDX_W = 5;

  localparam logic [6:0] OPC_RTYPE = 7'b0110011;
  localparam logic [6:0] OPC_ITYPE = 7'b0010011;

  localparam logic [6:0] F7_ZERO   = 7'b0000000;
  localparam logic [6:0] F7_ALT    = 7'b0100000;
  localparam logic [6:0] F7_MULDIV = 7'b0000001;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // Outcome of one instruction from the ALU.
  typedef struct packed {
    logic            ok;
    logic [XLEN-1:0] value;
  } alu_res_t;

endpackage

@@ rtl/rv32alu_ram.sv @@
// ----------------------------------------------------------------------------
// rv32alu_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module rv32alu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         qa,
  output logic [WIDTH-1:0]         qb
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Reads return the contents from before a write in the same cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      qa <= mem[raddr_a];
      qb <= mem[raddr_b];
    end
  end

endmodule

@@ rtl/rv32alu_core.sv @@
// ----------------------------------------------------------------------------
// rv32alu_core
// Decodes one R-type or I-type ALU instruction and computes its result.
// ----------------------------------------------------------------------------
module rv32alu_core (
  input  logic [rv32alu_pkg::XLEN-1:0] instr,
  input  logic [rv32alu_pkg::XLEN-1:0] op_a,
  input  logic [rv32alu_pkg::XLEN-1:0] op_b,
  output rv32alu_pkg::alu_res_t        res
);
  import rv32alu_pkg::*;

  logic [6:0]      opc;
  logic [2:0]      f3;
  logic [6:0]      f7;
  logic [4:0]      shamt_i;
  logic [4:0]      shamt_r;
  logic [XLEN-1:0] imm;
  logic [XLEN-1:0] prod;

  assign opc     = instr[6:0];
  assign f3      = instr[14:12];
  assign f7      = instr[31:25];
  assign shamt_i = instr[24:20];
  assign shamt_r = op_b[4:0];
  assign imm     = {{(XLEN-12){instr[31]}}, instr[31:20]};
  assign prod    = op_a * op_b;

  always_comb begin
    res.ok    = 1'b1;
    res.value = '0;
    unique case (opc)
      OPC_RTYPE: begin
        if (f7 == F7_ZERO) begin
          unique case (f3)
            F3_ADD:  res.value = op_a + op_b;
            F3_SLL:  res.value = op_a << shamt_r;
            F3_SLT:  res.value = {{(XLEN-1){1'b0}}, $signed(op_a) < $signed(op_b)};
            F3_SLTU: res.value = {{(XLEN-1){1'b0}}, op_a < op_b};
            F3_XOR:  res.value = op_a ^ op_b;
            F3_SR:   res.value = op_a >> shamt_r;
            F3_OR:   res.value = op_a | op_b;
            F3_AND:  res.value = op_a & op_b;
            default: res.ok = 1'b0;
          endcase
        end else if (f7 == F7_ALT && f3 == F3_ADD) begin
          res.value = op_a - op_b;
        end else if (f7 == F7_ALT && f3 == F3_SR) begin
          res.value = $unsigned($signed(op_a) >>> shamt_r);
        end else if (f7 == F7_MULDIV && f3 == F3_ADD) begin
          res.value = prod;
        end else begin
          res.ok = 1'b0;
        end
      end
      OPC_ITYPE: begin
        unique case (f3)
          F3_ADD:  res.value = op_a + imm;
          F3_SLL: begin
            if (f7 == F7_ZERO) begin
              res.value = op_a << shamt_i;
            end else begin
              res.ok = 1'b0;
            end
          end
          F3_SLT:  res.value = {{(XLEN-1){1'b0}}, $signed(op_a) < $signed(imm)};
          F3_SLTU: res.value = {{(XLEN-1){1'b0}}, op_a < imm};
          F3_XOR:  res.value = op_a ^ imm;
          F3_SR: begin
            if (f7 == F7_ZERO) begin
              res.value = op_a >> shamt_i;
            end else if (f7 == F7_ALT) begin
              res.value = $unsigned($signed(op_a) >>> shamt_i);
            end else begin
              res.ok = 1'b0;
            end
          end
          F3_OR:   res.value = op_a | imm;
          F3_AND:  res.value = op_a & imm;
          default: res.ok = 1'b0;
        endcase
      end
      default: res.ok = 1'b0;
    endcase
  end

endmodule

@@ rtl/rv32_alu_instruction_execute.sv @@
// ----------------------------------------------------------------------------
// rv32_alu_instruction_execute: RV32 ALU execute stage
// Pipeline: an accepted item moves from the first-stage register to the output register.
// Throughput: one item per cycle while the result side keeps up, set by the single ALU pass and the bypass.
// Reset: synchronous, active low; empties both stages and marks every register zero.
// ----------------------------------------------------------------------------
`include "rv32_alu_instruction_execute_macros.svh"

module rv32_alu_instruction_execute (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rv32alu_pkg::XLEN-1:0]      in_instruction_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rv32alu_pkg::RIDX_W-1:0]    out_dest_index,
  output logic signed [rv32alu_pkg::XLEN-1:0] out_result_value,
  output logic                              out_wrote_register,
  output logic                              out_unsupported
);
  import rv32alu_pkg::*;

  // The block has two stages. The first register holds the accepted item
  // together with its register file read data, which the RAM captures at the
  // same edge. The ALU runs between that register and the output register.
  // When an item leaves the first stage it is written back, and the item entering behind it
  // picks up the new value through a bypass register instead of the RAM.

  logic                accept;
  logic                s1_adv;
  logic                s1_valid_r;
  logic                s1_valid_nxt;
  logic [XLEN-1:0]     s1_instr_r;
  logic [RIDX_W-1:0]   in_rs1;
  logic [RIDX_W-1:0]   in_rs2;
  logic [RIDX_W-1:0]   s1_rd;

  // Register file: data in the RAM, one valid bit per entry in flip-flops.
  // An entry that was never written reads as zero, and x0 is never written.
  logic [NREGS-1:0]    rf_valid_r;
  logic [XLEN-1:0]     ram_qa;
  logic [XLEN-1:0]     ram_qb;
  logic                va_r;
  logic                vb_r;

  // Bypass of the value written at the edge where the reading item entered.
  logic                fwd_a_r;
  logic                fwd_b_r;
  logic [XLEN-1:0]     fwd_val_r;

  logic [XLEN-1:0]     op_a;
  logic [XLEN-1:0]     op_b;
  alu_res_t            alu_res;

  logic                wr_en;
  logic [RIDX_W-1:0]   wr_addr;
  logic [XLEN-1:0]     wr_data;

  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [RIDX_W-1:0]   out_rd_r;
  logic [XLEN-1:0]     out_val_r;
  logic                out_wr_r;
  logic                out_unsup_r;

  // Handshake. The first stage moves on whenever the output register is
  // empty or is being taken, so a new item enters in every cycle that the
  // result side keeps up.
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;

  assign in_rs1 = in_instruction_word[19:15];
  assign in_rs2 = in_instruction_word[24:20];
  assign s1_rd  = s1_instr_r[11:7];

  assign s1_valid_nxt  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rf_valid_r  <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        rf_valid_r[wr_addr] <= 1'b1;
      end
    end
  end

  // Payload of the first stage, captured with the RAM read.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_instr_r <= in_instruction_word;
      va_r       <= rf_valid_r[in_rs1];
      vb_r       <= rf_valid_r[in_rs2];
      fwd_a_r    <= wr_en && (wr_addr == in_rs1);
      fwd_b_r    <= wr_en && (wr_addr == in_rs2);
      fwd_val_r  <= wr_data;
    end
  end

  rv32alu_ram #(
    .WIDTH (XLEN),
    .DEPTH (NREGS)
  ) u_regfile (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (wr_addr),
    .wdata   (wr_data),
    .re      (accept),
    .raddr_a (in_rs1),
    .raddr_b (in_rs2),
    .qa      (ram_qa),
    .qb      (ram_qb)
  );

  assign op_a = fwd_a_r ? fwd_val_r : (va_r ? ram_qa : '0);
  assign op_b = fwd_b_r ? fwd_val_r : (vb_r ? ram_qb : '0);

  rv32alu_core u_core (
    .instr (s1_instr_r),
    .op_a  (op_a),
    .op_b  (op_b),
    .res   (alu_res)
  );

  // Write-back happens as the item leaves the first stage.
  assign wr_en   = s1_valid_r && s1_adv && alu_res.ok && (s1_rd != '0);
  assign wr_addr = s1_rd;
  assign wr_data = alu_res.value;

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_rd_r    <= s1_rd;
      out_wr_r    <= alu_res.ok && (s1_rd != '0);
      out_val_r   <= (alu_res.ok && (s1_rd != '0)) ? alu_res.value : '0;
      out_unsup_r <= !alu_res.ok;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_dest_index     = out_rd_r;
  assign out_result_value   = $signed(out_val_r);
  assign out_wrote_register = out_wr_r;
  assign out_unsupported    = out_unsup_r;

  // A result that wrote nothing carries a zero value and no write flag for x0.
  `RV32ALU_ASSERT_NOW(a_nowrite_zero, out_valid_r && !out_wr_r, out_val_r == '0)
  `RV32ALU_ASSERT_NOW(a_x0_never_written, wr_en, wr_addr != '0)
  // A written entry is marked valid from the next cycle on.
  `RV32ALU_ASSERT_NEXT(a_valid_set, wr_en, rf_valid_r[$past(wr_addr)])
  // A result that wrote a register came from a supported operation.
  `RV32ALU_ASSERT_NOW(a_wr_supported, out_valid_r && out_wr_r, !out_unsup_r && out_rd_r != '0)

endmodule
